FILE: rtl/ffnu_pkg.sv
// Shared widths, types and codes for the flat face normal unroller.
package ffnu_pkg;

  localparam int unsigned COORD_W    = 32;
  localparam int unsigned NUM_AXES   = 3;
  localparam int unsigned NUM_PTS    = 9;
  localparam int unsigned POS_W      = NUM_PTS * COORD_W;
  localparam int unsigned CORNER_W   = NUM_AXES * COORD_W;
  localparam int unsigned DIFF_W     = COORD_W + 1;
  localparam int unsigned PROD_W     = 2 * DIFF_W;
  localparam int unsigned CROSS_W    = PROD_W + 1;
  localparam int unsigned SPLIT_W    = 34;
  localparam int unsigned HI_W       = CROSS_W - SPLIT_W;
  localparam int unsigned SQ_W       = 2 * CROSS_W;
  localparam int unsigned SUM_W      = SQ_W + 2;
  localparam int unsigned QW         = 15;
  localparam int unsigned NORM_W     = 16;
  localparam int unsigned NRM_VEC_W  = NUM_AXES * NORM_W;
  localparam int unsigned FRAC_SHIFT = 28;
  localparam int unsigned ACC_W      = 168;
  localparam int unsigned IN_DATA_W  = POS_W;
  localparam int unsigned OUT_DATA_W = CORNER_W + NRM_VEC_W;
  localparam int unsigned FIFO_DEPTH = 16;

  typedef enum logic [1:0] {
    CORNER_A,
    CORNER_B,
    CORNER_C
  } corner_e;

  typedef struct packed {
    logic pos_valid;
    logic nrm_valid;
  } head_status_t;

endpackage

FILE: rtl/flat_face_normal_unroller.sv
// Throughput: three output transactions per triangle, one corner per cycle while
// m_axis_tready_i is high; the single result channel sets the sustained triangle rate.
// The normal pipeline takes a triangle every cycle while the position queue has room.
// Reset clears the queues, the pipeline valid bits and the output register valid.
module flat_face_normal_unroller #(
  parameter int unsigned FIFO_DEPTH = ffnu_pkg::FIFO_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
  input  logic [ffnu_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  input  logic                            s_axis_tlast_i,   // mesh_end
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z
  output logic [ffnu_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic                            m_axis_tlast_o,   // corner_last
  output logic                            m_axis_tuser_o    // mesh_last
);

  logic                           in_xfer, pos_full, pop;
  logic                           nrm_valid, nrm_full;
  logic [ffnu_pkg::NRM_VEC_W-1:0] nrm, nrm_head;
  logic [ffnu_pkg::POS_W:0]       pos_head;
  ffnu_pkg::head_status_t         status;

  assign s_axis_tready_o = !pos_full && !nrm_full;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  ffnu_normal u_normal (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_xfer),
    .pts_i       (s_axis_tdata_i),
    .nrm_valid_o (nrm_valid),
    .nrm_o       (nrm)
  );

  // positions queue at accept time; each in-flight normal owns an entry
  ffnu_fifo #(
    .WIDTH (ffnu_pkg::POS_W + 1),
    .DEPTH (FIFO_DEPTH)
  ) u_pos_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_xfer),
    .wdata_i ({s_axis_tlast_i, s_axis_tdata_i}),
    .pop_i   (pop),
    .rdata_o (pos_head),
    .valid_o (status.pos_valid),
    .full_o  (pos_full)
  );

  ffnu_fifo #(
    .WIDTH (ffnu_pkg::NRM_VEC_W),
    .DEPTH (FIFO_DEPTH)
  ) u_nrm_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (nrm_valid),
    .wdata_i (nrm),
    .pop_i   (pop),
    .rdata_o (nrm_head),
    .valid_o (status.nrm_valid),
    .full_o  (nrm_full)
  );

  ffnu_emit u_emit (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .status_i        (status),
    .pos_i           (pos_head),
    .nrm_i           (nrm_head),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

FILE: rtl/ffnu_fifo.sv
// Small first-in first-out queue feeding the corner emitter, for positions and for normals.
module ffnu_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             valid_o,
  output logic             full_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

FILE: rtl/ffnu_normal.sv
// Pipelined exact cross product and bit-per-stage unit normal search.
module ffnu_normal (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic [ffnu_pkg::POS_W-1:0]     pts_i,
  output logic                           nrm_valid_o,
  output logic [ffnu_pkg::NRM_VEC_W-1:0] nrm_o
);

  localparam int unsigned Ax    = ffnu_pkg::NUM_AXES;
  localparam int unsigned CW    = ffnu_pkg::COORD_W;
  localparam int unsigned QW    = ffnu_pkg::QW;
  localparam int unsigned AccW  = ffnu_pkg::ACC_W;
  localparam int unsigned SplW  = ffnu_pkg::SPLIT_W;
  localparam int unsigned HiW   = ffnu_pkg::HI_W;
  localparam int unsigned PreN  = 6;

  logic signed [ffnu_pkg::DIFF_W-1:0]  e_q [Ax];
  logic signed [ffnu_pkg::DIFF_W-1:0]  f_q [Ax];
  logic signed [ffnu_pkg::PROD_W-1:0]  pa_q [Ax];
  logic signed [ffnu_pkg::PROD_W-1:0]  pb_q [Ax];
  logic signed [ffnu_pkg::CROSS_W-1:0] n_q [Ax];
  logic [ffnu_pkg::CROSS_W-1:0]        mag_q [Ax];
  logic [Ax-1:0]                       neg4_q, neg5_q, neg6_q;
  logic [2*HiW-1:0]                    hh_q [Ax];
  logic [HiW+SplW-1:0]                 hl_q [Ax];
  logic [2*SplW-1:0]                   ll_q [Ax];
  logic [ffnu_pkg::SQ_W-1:0]           sq_q [Ax];

  // search state, index 0 is the entry of the search chain
  logic [AccW-1:0]                     rem_q  [QW+1][Ax];
  logic [AccW-1:0]                     acc_q  [QW+1][Ax];
  logic [QW-1:0]                       q_q    [QW+1][Ax];
  logic [ffnu_pkg::SUM_W-1:0]          sum_q  [QW+1];
  logic [Ax-1:0]                       neg_q  [QW+1];
  logic [QW:0]                         zero_q;
  logic [AccW-1:0]                     diff   [QW][Ax];

  logic [PreN-1:0] pre_v_q;
  logic [QW:0]     vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_v_q <= '0;
      vld_q   <= '0;
    end else begin
      pre_v_q <= {pre_v_q[PreN-2:0], in_valid_i};
      vld_q   <= {vld_q[QW-1:0], pre_v_q[PreN-1]};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < Ax; k++) begin
      e_q[k] <= $signed({pts_i[k*CW+CW-1], pts_i[k*CW +: CW]})
              - $signed({pts_i[(k+6)*CW+CW-1], pts_i[(k+6)*CW +: CW]});
      f_q[k] <= $signed({pts_i[(k+3)*CW+CW-1], pts_i[(k+3)*CW +: CW]})
              - $signed({pts_i[(k+6)*CW+CW-1], pts_i[(k+6)*CW +: CW]});
    end
    // n = e x f
    pa_q[0] <= e_q[1] * f_q[2];
    pb_q[0] <= e_q[2] * f_q[1];
    pa_q[1] <= e_q[2] * f_q[0];
    pb_q[1] <= e_q[0] * f_q[2];
    pa_q[2] <= e_q[0] * f_q[1];
    pb_q[2] <= e_q[1] * f_q[0];
    for (int k = 0; k < Ax; k++) begin
      n_q[k]    <= ffnu_pkg::CROSS_W'(pa_q[k]) - ffnu_pkg::CROSS_W'(pb_q[k]);
      neg4_q[k] <= n_q[k][ffnu_pkg::CROSS_W-1];
      mag_q[k]  <= n_q[k][ffnu_pkg::CROSS_W-1] ? ffnu_pkg::CROSS_W'(-n_q[k])
                                                : ffnu_pkg::CROSS_W'(n_q[k]);
      // square of the magnitude from split halves
      hh_q[k]   <= mag_q[k][SplW +: HiW] * mag_q[k][SplW +: HiW];
      hl_q[k]   <= mag_q[k][SplW +: HiW] * mag_q[k][SplW-1:0];
      ll_q[k]   <= mag_q[k][SplW-1:0] * mag_q[k][SplW-1:0];
      sq_q[k]   <= (ffnu_pkg::SQ_W'(hh_q[k]) << (2 * SplW))
                 + (ffnu_pkg::SQ_W'(hl_q[k]) << (SplW + 1))
                 + ffnu_pkg::SQ_W'(ll_q[k]);
    end
    neg5_q <= neg4_q;
    neg6_q <= neg5_q;

    // entry of the search: remainder 2^28 m^2, partial q*S is zero
    sum_q[0]  <= ffnu_pkg::SUM_W'(sq_q[0]) + ffnu_pkg::SUM_W'(sq_q[1])
               + ffnu_pkg::SUM_W'(sq_q[2]);
    zero_q[0] <= ((sq_q[0] | sq_q[1] | sq_q[2]) == '0);
    neg_q[0]  <= neg6_q;
    for (int k = 0; k < Ax; k++) begin
      rem_q[0][k] <= AccW'(sq_q[k]) << ffnu_pkg::FRAC_SHIFT;
      acc_q[0][k] <= '0;
      q_q[0][k]   <= '0;
    end

    // one quotient bit per stage: try q + 2^j while q^2 S <= 2^28 m^2
    for (int s = 0; s < QW; s++) begin
      sum_q[s+1]  <= sum_q[s];
      zero_q[s+1] <= zero_q[s];
      neg_q[s+1]  <= neg_q[s];
      for (int k = 0; k < Ax; k++) begin
        if (!diff[s][k][AccW-1]) begin
          rem_q[s+1][k] <= diff[s][k];
          acc_q[s+1][k] <= acc_q[s][k] + (AccW'(sum_q[s]) << (QW - 1 - s));
          q_q[s+1][k]   <= q_q[s][k] | (QW'(1) << (QW - 1 - s));
        end else begin
          rem_q[s+1][k] <= rem_q[s][k];
          acc_q[s+1][k] <= acc_q[s][k];
          q_q[s+1][k]   <= q_q[s][k];
        end
      end
    end
  end

  always_comb begin
    for (int s = 0; s < QW; s++) begin
      for (int k = 0; k < Ax; k++) begin
        diff[s][k] = rem_q[s][k] - (acc_q[s][k] << (QW - s))
                   - (AccW'(sum_q[s]) << (2 * (QW - 1 - s)));
      end
    end
  end

  always_comb begin
    for (int k = 0; k < Ax; k++) begin
      if (zero_q[QW]) begin
        nrm_o[k*ffnu_pkg::NORM_W +: ffnu_pkg::NORM_W] = '0;
      end else if (neg_q[QW][k]) begin
        nrm_o[k*ffnu_pkg::NORM_W +: ffnu_pkg::NORM_W] =
          ffnu_pkg::NORM_W'(-ffnu_pkg::NORM_W'(q_q[QW][k]));
      end else begin
        nrm_o[k*ffnu_pkg::NORM_W +: ffnu_pkg::NORM_W] = ffnu_pkg::NORM_W'(q_q[QW][k]);
      end
    end
  end

  assign nrm_valid_o = vld_q[QW];

endmodule

FILE: rtl/ffnu_emit.sv
// Back end: unrolls one queued triangle into three corner transactions.
module ffnu_emit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ffnu_pkg::head_status_t          status_i,
  input  logic [ffnu_pkg::POS_W:0]        pos_i,
  input  logic [ffnu_pkg::NRM_VEC_W-1:0]  nrm_i,
  output logic                            pop_o,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [ffnu_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic                            m_axis_tlast_o,
  output logic                            m_axis_tuser_o
);

  localparam int unsigned CrW = ffnu_pkg::CORNER_W;

  ffnu_pkg::corner_e              state_q, state_d;
  logic                           valid_q, valid_d;
  logic                           load;
  logic [ffnu_pkg::OUT_DATA_W-1:0] data_q, data_d;
  logic                           last_q, last_d, user_q, user_d;

  always_comb begin
    load    = (!valid_q || m_axis_tready_i) && status_i.pos_valid && status_i.nrm_valid;
    state_d = state_q;
    valid_d = valid_q;
    data_d  = data_q;
    last_d  = last_q;
    user_d  = user_q;
    pop_o   = 1'b0;
    if (!valid_q || m_axis_tready_i) begin
      valid_d = status_i.pos_valid && status_i.nrm_valid;
    end
    if (load) begin
      unique case (state_q)
        ffnu_pkg::CORNER_A: begin
          data_d  = {nrm_i, pos_i[0 +: CrW]};
          last_d  = 1'b0;
          user_d  = 1'b0;
          state_d = ffnu_pkg::CORNER_B;
        end
        ffnu_pkg::CORNER_B: begin
          data_d  = {nrm_i, pos_i[CrW +: CrW]};
          last_d  = 1'b0;
          user_d  = 1'b0;
          state_d = ffnu_pkg::CORNER_C;
        end
        ffnu_pkg::CORNER_C: begin
          data_d  = {nrm_i, pos_i[2*CrW +: CrW]};
          last_d  = 1'b1;
          user_d  = pos_i[ffnu_pkg::POS_W];
          state_d = ffnu_pkg::CORNER_A;
          pop_o   = 1'b1;
        end
        default: begin
          state_d = ffnu_pkg::CORNER_A;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffnu_pkg::CORNER_A;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    last_q <= last_d;
    user_q <= user_d;
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = data_q;
  assign m_axis_tlast_o  = last_q;
  assign m_axis_tuser_o  = user_q;

endmodule

FILE: rtl/ffnu_checker.sv
// Port-level checks on the corner stream, bound to the top level.
module ffnu_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [ffnu_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic                            m_axis_tlast_o,
  input logic                            m_axis_tuser_o
);

  localparam int unsigned NrmLo = ffnu_pkg::CORNER_W;

  logic                           xfer;
  logic [1:0]                     cnt_q;
  logic [ffnu_pkg::NRM_VEC_W-1:0] nrm_prev_q;

  assign xfer = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (xfer) begin
      cnt_q <= (cnt_q == 2'd2) ? 2'd0 : cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (xfer) begin
      nrm_prev_q <= m_axis_tdata_o[NrmLo +: ffnu_pkg::NRM_VEC_W];
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tlast_o) && $stable(m_axis_tuser_o))
    else $error("output changed while stalled");

  a_user_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o)
    else $error("mesh end mark off the third corner");

  a_third: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer |-> (m_axis_tlast_o == (cnt_q == 2'd2)))
    else $error("corner last mark out of step");

  a_shared_nrm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && cnt_q != 2'd0 |-> m_axis_tdata_o[NrmLo +: ffnu_pkg::NRM_VEC_W] == nrm_prev_q)
    else $error("normal differs between corners of one triangle");

endmodule

bind flat_face_normal_unroller ffnu_checker u_ffnu_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
